### hdl/gtf_gff3_attribute_tokenizer_unit_assert.svh
// Assertion macros for the attribute tokenizer
`ifndef GTF_GFF3_ATTRIBUTE_TOKENIZER_UNIT_ASSERT_SVH
`define GTF_GFF3_ATTRIBUTE_TOKENIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define GTU_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("tokenizer check failed");
`define GTU_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("tokenizer forbidden condition");
`else
`define GTU_ASSERT(label, clk, rstn, prop)
`define GTU_ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

### hdl/gtf_tok_pkg.sv
package gtf_tok_pkg;

    typedef enum logic [2:0] {
        PH_SKIP      = 3'd0,
        PH_KEY       = 3'd1,
        PH_AFTER_KEY = 3'd2,
        PH_QUOTED    = 3'd3,
        PH_BARE      = 3'd4,
        PH_TAIL      = 3'd5,
        PH_G_KEY     = 3'd6,
        PH_G_VALUE   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic MODE_GTF  = 1'b0;
    localparam logic MODE_GFF3 = 1'b1;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB);
    endfunction

endpackage

### hdl/gtf_gff3_attribute_tokenizer_unit.sv
// Each accepted s_ byte goes through the input register, then the result register.
// Throughput: one byte per cycle; m_ stalls back up through one input register.
// Bytes that produce no result are consumed at the input register and emit nothing.
// Reset (aresetn low, synchronous): both stages empty, phase SKIP, mode GTF.
`include "gtf_gff3_attribute_tokenizer_unit_assert.svh"

module gtf_gff3_attribute_tokenizer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_format_mode,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_token_kind,
    output logic [7:0] m_char_out
);
    import gtf_tok_pkg::*;

    logic       mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_char_reg;

    logic       fire;
    logic       emit;
    kind_t      kind;
    logic [7:0] ch;
    logic [7:0] c;

    logic       fire_nul;
    logic       out_end;
    logic       out_data;
    logic       enter_tail;

    assign c         = in_char_reg;
    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_valid_reg;
    assign m_token_kind = out_kind_reg;
    assign m_char_out   = out_char_reg;

    always_comb begin
        phase_next = phase_reg;
        if (c == CHAR_NUL) begin
            phase_next = PH_SKIP;
        end else begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (!is_blank(c)) begin
                        if (mode_reg == MODE_GFF3) begin
                            if (c == CHAR_EQ) begin
                                phase_next = PH_G_VALUE;
                            end else if (c != CHAR_SEMI) begin
                                phase_next = PH_G_KEY;
                            end
                        end else if (c != CHAR_SEMI) begin
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    if (is_blank(c)) begin
                        phase_next = PH_AFTER_KEY;
                    end else if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_AFTER_KEY: begin
                    if (c == CHAR_QUOTE) begin
                        phase_next = PH_QUOTED;
                    end else if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end else if (!is_blank(c)) begin
                        phase_next = PH_BARE;
                    end
                end
                PH_QUOTED: begin
                    if (c == CHAR_QUOTE) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_BARE: begin
                    if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end else if (is_blank(c)) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_G_KEY: begin
                    if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end else if (c == CHAR_EQ) begin
                        phase_next = PH_G_VALUE;
                    end
                end
                PH_G_VALUE: begin
                    if (c == CHAR_SEMI) begin
                        phase_next = PH_SKIP;
                    end
                end
                default: begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_comb begin
        emit = 1'b0;
        kind = KIND_END;
        ch   = CHAR_NUL;
        if (c == CHAR_NUL) begin
            emit = (phase_reg != PH_SKIP) && (phase_reg != PH_TAIL);
        end else begin
            unique case (phase_reg)
                PH_SKIP: begin
                    if (!is_blank(c)) begin
                        if (mode_reg == MODE_GFF3) begin
                            if (c == CHAR_SEMI) begin
                                emit = 1'b1;
                            end else if (c != CHAR_EQ) begin
                                emit = 1'b1;
                                kind = KIND_KEY;
                                ch   = c;
                            end
                        end else if (c != CHAR_SEMI) begin
                            emit = 1'b1;
                            kind = KIND_KEY;
                            ch   = c;
                        end
                    end
                end
                PH_KEY, PH_G_KEY: begin
                    if (c == CHAR_SEMI) begin
                        emit = 1'b1;
                    end else if (phase_reg == PH_KEY ? !is_blank(c) : (c != CHAR_EQ)) begin
                        emit = 1'b1;
                        kind = KIND_KEY;
                        ch   = c;
                    end
                end
                PH_AFTER_KEY: begin
                    if (c == CHAR_SEMI) begin
                        emit = 1'b1;
                    end else if (!is_blank(c) && (c != CHAR_QUOTE)) begin
                        emit = 1'b1;
                        kind = KIND_VALUE;
                        ch   = c;
                    end
                end
                PH_QUOTED: begin
                    emit = 1'b1;
                    if (c != CHAR_QUOTE) begin
                        kind = KIND_VALUE;
                        ch   = c;
                    end
                end
                PH_BARE: begin
                    emit = 1'b1;
                    if ((c != CHAR_SEMI) && !is_blank(c)) begin
                        kind = KIND_VALUE;
                        ch   = c;
                    end
                end
                PH_TAIL: begin
                    emit = 1'b0;
                end
                PH_G_VALUE: begin
                    emit = 1'b1;
                    if (c != CHAR_SEMI) begin
                        kind = KIND_VALUE;
                        ch   = c;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_GTF;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_format_mode;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                phase_reg     <= phase_next;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
        end
        if (fire && emit) begin
            out_kind_reg <= kind;
            out_char_reg <= ch;
        end
    end

    assign fire_nul   = fire && (in_char_reg == CHAR_NUL);
    assign out_end    = out_valid_reg && (out_kind_reg == KIND_END);
    assign out_data   = out_valid_reg && (out_kind_reg != KIND_END);
    assign enter_tail = fire && (phase_next == PH_TAIL) && (phase_reg != PH_TAIL);

    `GTU_ASSERT(a_nul_returns_to_skip, aclk, aresetn, fire_nul |=> (phase_reg == PH_SKIP))
    `GTU_ASSERT(a_pair_end_has_nul, aclk, aresetn, out_end |-> (out_char_reg == CHAR_NUL))
    `GTU_ASSERT(a_data_byte_nonzero, aclk, aresetn, out_data |-> (out_char_reg != CHAR_NUL))
    `GTU_ASSERT(a_tail_after_end, aclk, aresetn, enter_tail |=> out_end)
    `GTU_ASSERT_NEVER(a_no_overwrite, aclk, aresetn, fire && emit && out_valid_reg && !m_ready)

endmodule

### bench/gtf_gff3_attribute_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module gtf_gff3_attribute_tokenizer_unit_tb;

    import gtf_tok_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
    } token_t;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 64;
    localparam int HOLD_AFTER  = 200;
    localparam int DRAIN_WAIT  = 8;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       cfg_valid       = 1'b0;
    logic       cfg_ready;
    logic       cfg_format_mode = MODE_GTF;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in       = CHAR_NUL;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [1:0] m_token_kind;
    logic [7:0] m_char_out;

    logic [7:0] byte_feed[$];
    token_t     expected_tokens[$];
    token_t     head_token;
    phase_t     phase_q    = PH_SKIP;
    logic       mode_q     = MODE_GTF;
    logic       steady     = 1'b0;
    logic       hold_done  = 1'b0;
    int         hold_left  = 0;
    int         items_taken = 0;
    int         fed_count  = 0;
    int         fail_count = 0;
    int         stall_cycles = 0;
    logic [7:0] specials[6] = '{CHAR_NUL, CHAR_SEMI, CHAR_EQ,
                                CHAR_QUOTE, CHAR_SPACE, CHAR_TAB};

    gtf_gff3_attribute_tokenizer_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_format_mode (cfg_format_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_char_out      (m_char_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void expect_token(input kind_t k, input logic [7:0] c);
        expected_tokens.push_back(token_t'{k, c});
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c);
        logic blank;
        blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
        if (c == CHAR_NUL) begin
            if (phase_q != PH_SKIP && phase_q != PH_TAIL)
                expect_token(KIND_END, CHAR_NUL);
            phase_q = PH_SKIP;
        end else begin
            case (phase_q)
                PH_SKIP: begin
                    if (blank) begin
                    end else if (mode_q == MODE_GFF3) begin
                        if (c == CHAR_SEMI) begin
                            expect_token(KIND_END, CHAR_NUL);
                        end else if (c == CHAR_EQ) begin
                            phase_q = PH_G_VALUE;
                        end else begin
                            phase_q = PH_G_KEY;
                            expect_token(KIND_KEY, c);
                        end
                    end else if (c != CHAR_SEMI) begin
                        phase_q = PH_KEY;
                        expect_token(KIND_KEY, c);
                    end
                end
                PH_KEY: begin
                    if (blank) begin
                        phase_q = PH_AFTER_KEY;
                    end else if (c == CHAR_SEMI) begin
                        phase_q = PH_SKIP;
                        expect_token(KIND_END, CHAR_NUL);
                    end else begin
                        expect_token(KIND_KEY, c);
                    end
                end
                PH_AFTER_KEY: begin
                    if (blank) begin
                    end else if (c == CHAR_QUOTE) begin
                        phase_q = PH_QUOTED;
                    end else if (c == CHAR_SEMI) begin
                        phase_q = PH_SKIP;
                        expect_token(KIND_END, CHAR_NUL);
                    end else begin
                        phase_q = PH_BARE;
                        expect_token(KIND_VALUE, c);
                    end
                end
                PH_QUOTED: begin
                    if (c == CHAR_QUOTE) begin
                        phase_q = PH_TAIL;
                        expect_token(KIND_END, CHAR_NUL);
                    end else begin
                        expect_token(KIND_VALUE, c);
                    end
                end
                PH_BARE: begin
                    if (c == CHAR_SEMI) begin
                        phase_q = PH_SKIP;
                        expect_token(KIND_END, CHAR_NUL);
                    end else if (blank) begin
                        phase_q = PH_TAIL;
                        expect_token(KIND_END, CHAR_NUL);
                    end else begin
                        expect_token(KIND_VALUE, c);
                    end
                end
                PH_TAIL: begin
                    if (c == CHAR_SEMI)
                        phase_q = PH_SKIP;
                end
                PH_G_KEY: begin
                    if (c == CHAR_SEMI) begin
                        phase_q = PH_SKIP;
                        expect_token(KIND_END, CHAR_NUL);
                    end else if (c == CHAR_EQ) begin
                        phase_q = PH_G_VALUE;
                    end else begin
                        expect_token(KIND_KEY, c);
                    end
                end
                default: begin
                    if (c == CHAR_SEMI) begin
                        phase_q = PH_SKIP;
                        expect_token(KIND_END, CHAR_NUL);
                    end else begin
                        expect_token(KIND_VALUE, c);
                    end
                end
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_char_in <= CHAR_NUL;
        end else begin
            if (s_valid && s_ready) begin
                tokenize_byte(s_char_in);
                items_taken <= items_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (byte_feed.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                    s_valid   <= 1'b1;
                    s_char_in <= byte_feed.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result: token_kind %0d char_out 0x%02h",
                       m_token_kind, m_char_out);
                fail_count++;
            end else begin
                head_token = expected_tokens.pop_front();
                if (m_token_kind !== head_token.kind) begin
                    $error("token_kind: expected %0d, actual %0d",
                           head_token.kind, m_token_kind);
                    fail_count++;
                end
                if (m_char_out !== head_token.ch) begin
                    $error("char_out: expected 0x%02h, actual 0x%02h",
                           head_token.ch, m_char_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] c);
        byte_feed.push_back(c);
        fed_count++;
    endtask

    task automatic push_str(input string s);
        foreach (s[i])
            push_byte(s[i]);
    endtask

    task automatic push_blanks(input int n);
        repeat (n)
            push_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_SEMI || c == CHAR_EQ || c == CHAR_QUOTE
               || c == CHAR_SPACE || c == CHAR_TAB);
        return c;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_QUOTE);
        return c;
    endfunction

    task automatic close_line();
        if ($urandom_range(4) != 0)
            push_byte(CHAR_NUL);
    endtask

    task automatic gen_gtf_line();
        repeat ($urandom_range(1, 4)) begin
            push_blanks($urandom_range(0, 2));
            repeat ($urandom_range(1, 6)) push_byte(plain_byte());
            push_blanks($urandom_range(1, 2));
            case ($urandom_range(3))
                0, 1: begin
                    push_byte(CHAR_QUOTE);
                    repeat ($urandom_range(0, 6)) push_byte(quoted_byte());
                    push_byte(CHAR_QUOTE);
                    repeat ($urandom_range(0, 2)) push_byte(plain_byte());
                end
                2: begin
                    repeat ($urandom_range(1, 5)) push_byte(plain_byte());
                end
                default: begin
                    repeat ($urandom_range(1, 5)) push_byte(plain_byte());
                    push_blanks(1);
                    repeat ($urandom_range(0, 2)) push_byte(plain_byte());
                end
            endcase
            push_byte(CHAR_SEMI);
        end
        close_line();
    endtask

    task automatic gen_gff3_line();
        repeat ($urandom_range(1, 4)) begin
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(5) == 0) begin
                push_byte(CHAR_SEMI);
            end else begin
                repeat ($urandom_range(0, 5)) push_byte(plain_byte());
                push_byte(CHAR_EQ);
                repeat ($urandom_range(0, 5))
                    push_byte(($urandom_range(7) == 0) ? CHAR_EQ : plain_byte());
                push_byte(CHAR_SEMI);
            end
        end
        close_line();
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 8))
            push_byte($urandom_range(1) ? specials[$urandom_range(5)]
                                        : 8'($urandom_range(255)));
    endtask

    task automatic fill_random(input int count, input logic gff3);
        int start;
        int pick;
        start = fed_count;
        while (fed_count - start < count) begin
            pick = $urandom_range(99);
            if (pick < 15)
                gen_noise();
            else if (gff3)
                gen_gff3_line();
            else
                gen_gtf_line();
        end
    endtask

    task automatic wait_drained();
        while (byte_feed.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_format_mode <= m;
        do
            @(posedge aclk);
        while (!cfg_ready);
        mode_q = m;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // GTF: empty key, quoted value with tail, high bytes, bare value ended by a blank
        push_str(";k \"");
        push_byte(8'hFF);
        push_str("\";");
        push_byte(8'h80);
        push_str("\tb ");
        push_byte(CHAR_NUL);
        push_str("k ");
        wait_drained();

        // switch to GFF3 with a GTF pair still open, then GFF3 corner cases
        write_mode(MODE_GFF3);
        push_str("v;;=z");
        push_byte(CHAR_NUL);
        push_str(" k=a=;q");
        push_byte(CHAR_NUL);
        wait_drained();

        fill_random(100, MODE_GFF3);
        wait_drained();

        write_mode(MODE_GTF);
        steady = 1'b1;
        fill_random(100, MODE_GTF);
        wait_drained();
        steady = 1'b0;

        fill_random(100, MODE_GTF);
        wait_drained();

        write_mode(MODE_GFF3);
        fill_random(100, MODE_GFF3);
        wait_drained();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
